/* design/ttip_pkg.sv */
// ttip_pkg: types, character codes and the digit decoder shared by the
// text-to-integer parser modules. No dependencies.
`default_nettype none

package ttip_pkg;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned DIGIT_W  = 7;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

  // Register indexes (paddr[2])
  localparam logic REG_RADIX  = 1'b0;
  localparam logic REG_SIGNED = 1'b1;

  typedef enum logic [5:0] {
    PH_DONE   = 6'b000001,
    PH_WS1    = 6'b000010,
    PH_WS2    = 6'b000100,
    PH_PREFIX = 6'b001000,
    PH_AFTER0 = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic                negative;
    logic [VALUE_W-1:0]  acc;
    logic [RADIX_W-1:0]  base;
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
    logic                end_valid;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Value of a digit or letter, DIGIT_NONE for anything else
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(DIGIT_NONE);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d = c - CH_ZERO;
    end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
      d = c - CH_LOWER_A + 8'd10;
    end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      d = c - CH_UPPER_A + 8'd10;
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/ttip_if.sv */
// ttip_if: valid/ready stream interfaces for the character beats going in
// and the parsed-number beats coming out. No dependencies.
`default_nettype none

interface ttip_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface ttip_out_if ();
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [15:0] end_offset;
  logic        end_valid;

  modport source (output valid, output value, output end_offset, output end_valid,
                  input ready);
  modport sink   (input valid, input value, input end_offset, input end_valid,
                  output ready);
endinterface

`default_nettype wire

/* design/ttip_cfg_regs.sv */
// ttip_cfg_regs: APB-style register file holding radix and signed_mode.
// Depends on ttip_pkg.
`default_nettype none

module ttip_cfg_regs import ttip_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [RADIX_W-1:0] radix_r;
  logic               signed_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_DEC;
      signed_r <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_RADIX:  radix_r  <= pwdata[RADIX_W-1:0];
        REG_SIGNED: signed_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RADIX:  prdata = {{(32-RADIX_W){1'b0}}, radix_r};
      REG_SIGNED: prdata = {31'd0, signed_r};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg.radix       = radix_r;
  assign cfg.signed_mode = signed_r;

endmodule

`default_nettype wire

/* design/ttip_step.sv */
// ttip_step: next-state and result logic for one character of the string.
// Depends on ttip_pkg.
`default_nettype none

module ttip_step import ttip_pkg::*; #(
  parameter int unsigned MAX_OFFSET = 32'd65535
) (
  input  wire logic [7:0]  ch,
  input  wire logic        start_req,
  input  wire cfg_t        cfg,
  input  wire state_t      cur,
  input  wire logic [$clog2(64'(MAX_OFFSET) + 64'd1)-1:0] cur_pos,
  output state_t           nxt,
  output logic [$clog2(64'(MAX_OFFSET) + 64'd1)-1:0] nxt_pos,
  output logic             emit,
  output result_t          res
);

  localparam int unsigned POS_W = $clog2(64'(MAX_OFFSET) + 64'd1);

  logic               go;
  logic [DIGIT_W-1:0] d;
  logic [31:0]        pos_wide;

  assign d = digit_of(ch);

  always_comb begin
    nxt      = cur;
    nxt_pos  = cur_pos;
    emit     = 1'b0;
    res      = '0;
    go       = 1'b1;
    pos_wide = 32'd0;

    if (start_req) begin
      nxt.acc      = '0;
      nxt.negative = 1'b0;
      nxt_pos      = '0;
      nxt.base     = cfg.radix;
      if ((cfg.radix == RADIX_ONE) || (cfg.radix > RADIX_MAX)) begin
        // bad base: empty result straight away
        emit      = 1'b1;
        nxt.phase = PH_DONE;
        go        = 1'b0;
      end else begin
        nxt.phase = cfg.signed_mode ? PH_WS1 : PH_WS2;
      end
    end

    if (go && (nxt.phase == PH_DONE)) begin
      go = 1'b0;
    end

    if (go && (nxt.phase == PH_WS1)) begin
      if (is_space(ch)) begin
        go = 1'b0;
      end else if (ch == CH_MINUS) begin
        nxt.negative = 1'b1;
        nxt.phase    = PH_WS2;
        go           = 1'b0;
      end else begin
        nxt.phase = PH_WS2;
      end
      if (!go && (nxt_pos < POS_W'(MAX_OFFSET))) nxt_pos = nxt_pos + 1'b1;
    end

    if (go && (nxt.phase == PH_WS2)) begin
      if (is_space(ch)) begin
        go = 1'b0;
        if (nxt_pos < POS_W'(MAX_OFFSET)) nxt_pos = nxt_pos + 1'b1;
      end else begin
        nxt.phase = (nxt.base == RADIX_AUTO) ? PH_PREFIX : PH_DIGITS;
      end
    end

    if (go && (nxt.phase == PH_PREFIX)) begin
      if (ch == CH_ZERO) begin
        nxt.phase = PH_AFTER0;
        go        = 1'b0;
        if (nxt_pos < POS_W'(MAX_OFFSET)) nxt_pos = nxt_pos + 1'b1;
      end else begin
        nxt.base  = RADIX_DEC;
        nxt.phase = PH_DIGITS;
      end
    end

    if (go && (nxt.phase == PH_AFTER0)) begin
      nxt.phase = PH_DIGITS;
      if ((ch == CH_LOWER_X) || (ch == CH_UPPER_X)) begin
        nxt.base = RADIX_HEX;
        go       = 1'b0;
        if (nxt_pos < POS_W'(MAX_OFFSET)) nxt_pos = nxt_pos + 1'b1;
      end else begin
        nxt.base = RADIX_OCT;
      end
    end

    // only the digits phase can still be pending here
    if (go) begin
      if (d < DIGIT_W'(nxt.base)) begin
        nxt.acc = nxt.acc * VALUE_W'(nxt.base) + VALUE_W'(d);
        if (nxt_pos < POS_W'(MAX_OFFSET)) nxt_pos = nxt_pos + 1'b1;
      end else begin
        emit          = 1'b1;
        nxt.phase     = PH_DONE;
        pos_wide      = 32'(nxt_pos);
        res.value     = nxt.negative ? (VALUE_W'(0) - nxt.acc) : nxt.acc;
        res.end_offset = (pos_wide > 32'd65535) ? 16'hffff : pos_wide[OFFSET_W-1:0];
        res.end_valid = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/text_to_integer_parser.sv */
// text_to_integer_parser: top level. Input beat register, per-character
// step logic and a result register. Depends on ttip_pkg, ttip_if,
// ttip_cfg_regs and ttip_step.
//
// Usage: characters stream in on in_bus, one beat each (ch, start_req);
// start_req marks the first character of a string and abandons any string
// in progress. Radix and signed_mode, written over the cfg_ APB port, are
// sampled on the start character. One beat comes out on out_bus for each
// string that is not abandoned, when its terminating character is processed
// (or on the start character for a bad base, with end_valid low).
// Throughput: one character per cycle unless a held result blocks it;
// the multiply-add of the accumulator by the base lies between the input
// register and the state. Result path: the terminating character is held in
// the input beat register, then the step logic loads the result register.
// Reset: parser returns to waiting for a start character, both channels
// empty, radix 10, signed mode on.
// Stall: a held result blocks only a character that would make the next
// result; until then in_bus keeps taking a beat per cycle.
`default_nettype none

module text_to_integer_parser import ttip_pkg::*; #(
  parameter int unsigned MAX_OFFSET = 32'd65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ttip_in_if.sink          in_bus,
  ttip_out_if.source       out_bus,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned POS_W = $clog2(64'(MAX_OFFSET) + 64'd1);

  cfg_t             cfg;
  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             in_valid_r;
  logic [7:0]       ch_r;
  logic             start_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;
  logic             emit;
  logic             fire;
  logic             can_step;

  ttip_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ttip_step #(.MAX_OFFSET(MAX_OFFSET)) u_step (
    .ch        (ch_r),
    .start_req (start_r),
    .cfg       (cfg),
    .cur       (state_r),
    .cur_pos   (pos_r),
    .nxt       (state_nxt),
    .nxt_pos   (pos_nxt),
    .emit      (emit),
    .res       (res_nxt)
  );

  // a character that makes a result waits for the result slot to free
  assign can_step     = !emit || !out_valid_r || out_bus.ready;
  assign fire         = in_valid_r && can_step;
  assign in_bus.ready = !in_valid_r || can_step;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_bus.ready) out_valid_nxt = 1'b0;
    if (fire && emit)                 out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r.phase <= PH_DONE;
      state_r.negative <= 1'b0;
      state_r.acc   <= '0;
      state_r.base  <= '0;
      pos_r         <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_bus.valid && in_bus.ready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        state_r <= state_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      ch_r    <= in_bus.ch;
      start_r <= in_bus.start_req;
    end
    if (fire && emit) res_r <= res_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.value      = res_r.value;
  assign out_bus.end_offset = res_r.end_offset;
  assign out_bus.end_valid  = res_r.end_valid;

endmodule

`default_nettype wire

/* design/ttip_checker.sv */
// ttip_checker: port-level assertions for text_to_integer_parser, bound to
// the top level. Depends on nothing beyond the top level's ports.
`default_nettype none

module ttip_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_value,
  input wire logic [15:0] out_end_offset,
  input wire logic        out_end_valid
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
    $stable(out_end_offset) && $stable(out_end_valid))
    else $error("result beat changed while stalled");

  // bad-base result is all zero
  a_bad_base: assert property (@(posedge clk)
    out_valid && !out_end_valid |-> (out_value == 64'd0) && (out_end_offset == 16'd0))
    else $error("invalid-base result carries data");

  // reset empties the result slot
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // with the result slot empty, input is never refused
  a_no_idle_stall: assert property (@(posedge clk) !out_valid |-> in_ready)
    else $error("input stalled with no pending result");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_value      (out_bus.value),
  .out_end_offset (out_bus.end_offset),
  .out_end_valid  (out_bus.end_valid)
);

`default_nettype wire

/* sim/tb_text_to_integer_parser.sv */
// Self-checking testbench for text_to_integer_parser: directed table plus
// random strings over a radix/sign sweep, checked beat by beat against a
// local parser model or the table's expected results. Depends on ttip_pkg, ttip_if and the design files.
`timescale 1ns / 1ps

module tb_text_to_integer_parser;
  import ttip_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [2:0] ADDR_RADIX  = {REG_RADIX, 2'b00};
  localparam logic [2:0] ADDR_SIGNED = {REG_SIGNED, 2'b00};

  localparam result_t NONE = '0;

  typedef enum bit {ROW_CHAR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [7:0]         ch;
    logic               start;
    logic               fixed;
    result_t            res;
    logic [RADIX_W-1:0] radix;
    logic               sgn;
  } dir_row_t;

  localparam int N_ROWS = 31;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_CHAR, CH_SPACE, 1'b1, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, CH_MINUS, 1'b0, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, CH_TAB,   1'b0, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, "9",      1'b0, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, ";",      1'b0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFF7, 16'd4, 1'b1}, 6'd0, 1'b0},
    // plus sign is not a sign here
    '{ROW_CHAR, "+",      1'b1, 1'b1, '{64'd0, 16'd0, 1'b1}, 6'd0, 1'b0},
    // idle character, parser waiting for a start
    '{ROW_CHAR, "z",      1'b0, 1'b0, NONE, 6'd0, 1'b0},
    // restart abandons the string in progress
    '{ROW_CHAR, "9",      1'b1, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, "4",      1'b1, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, 8'h00,    1'b0, 1'b1, '{64'd4, 16'd1, 1'b1}, 6'd0, 1'b0},
    '{ROW_CHAR, 8'hFF,    1'b1, 1'b1, '{64'd0, 16'd0, 1'b1}, 6'd0, 1'b0},
    '{ROW_CFG,  8'h00,    1'b0, 1'b0, NONE, RADIX_AUTO, 1'b1},
    // 0x with no hex digit after it
    '{ROW_CHAR, CH_ZERO,  1'b1, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, CH_LOWER_X, 1'b0, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, "g",      1'b0, 1'b1, '{64'd0, 16'd2, 1'b1}, 6'd0, 1'b0},
    '{ROW_CHAR, CH_ZERO,  1'b1, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, "7",      1'b0, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, "8",      1'b0, 1'b1, '{64'd7, 16'd2, 1'b1}, 6'd0, 1'b0},
    '{ROW_CFG,  8'h00,    1'b0, 1'b0, NONE, RADIX_MAX, 1'b0},
    '{ROW_CHAR, CH_MINUS, 1'b1, 1'b1, '{64'd0, 16'd0, 1'b1}, 6'd0, 1'b0},
    '{ROW_CHAR, "z",      1'b1, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, "Z",      1'b0, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, 8'h80,    1'b0, 1'b1, '{64'd1295, 16'd2, 1'b1}, 6'd0, 1'b0},
    '{ROW_CFG,  8'h00,    1'b0, 1'b0, NONE, RADIX_ONE, 1'b0},
    '{ROW_CHAR, "a",      1'b1, 1'b1, '{64'd0, 16'd0, 1'b0}, 6'd0, 1'b0},
    '{ROW_CFG,  8'h00,    1'b0, 1'b0, NONE, 6'd63, 1'b1},
    '{ROW_CHAR, "5",      1'b1, 1'b1, '{64'd0, 16'd0, 1'b0}, 6'd0, 1'b0},
    '{ROW_CFG,  8'h00,    1'b0, 1'b0, NONE, 6'd2, 1'b1},
    '{ROW_CHAR, "1",      1'b1, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, CH_ZERO,  1'b0, 1'b0, NONE, 6'd0, 1'b0},
    '{ROW_CHAR, "2",      1'b0, 1'b1, '{64'd2, 16'd2, 1'b1}, 6'd0, 1'b0}
  };

  localparam int N_SWEEP = 12;
  localparam logic [RADIX_W-1:0] SWEEP [N_SWEEP] = '{
    RADIX_DEC, RADIX_AUTO, RADIX_HEX, RADIX_OCT, 6'd2, RADIX_MAX,
    RADIX_ONE, 6'd37, 6'd63, RADIX_AUTO, 6'd35, RADIX_DEC
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ttip_in_if  in_bus ();
  ttip_out_if out_bus ();

  text_to_integer_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // register mirror and parser model state
  logic [RADIX_W-1:0]  cfg_radix = RADIX_DEC;
  logic                cfg_signed = 1'b1;
  phase_t              ps_phase = PH_DONE;
  logic                ps_neg = 1'b0;
  logic [VALUE_W-1:0]  ps_acc = '0;
  logic [RADIX_W-1:0]  ps_base = '0;
  logic [OFFSET_W-1:0] ps_pos = '0;

  result_t pending_nums[$];
  result_t pred_num;
  result_t want_num;
  bit      pred_hit;

  // tags that travel with each character beat
  logic    fixed_row = 1'b0;
  result_t fixed_res = '0;

  logic hold_long = 1'b0;
  logic rx_calm = 1'b0;
  bit   tx_calm = 1'b0;

  int errors = 0;
  int quiet = 0;
  int n_chars = 0;
  int n_nums = 0;
  int n_bad = 0;
  int n_neg = 0;
  int n_cfg = 0;

  always #2 clk = ~clk;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic int glyph_value(input logic [7:0] c);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) return int'(c - CH_ZERO);
    if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) return int'(c - CH_LOWER_A) + 10;
    if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) return int'(c - CH_UPPER_A) + 10;
    return 99;
  endfunction

  function automatic void bump_pos();
    if (ps_pos != 16'hFFFF) ps_pos = ps_pos + 16'd1;
  endfunction

  // Advances the parser model by one character; returns 1 if a number comes out
  function automatic bit parse_char(input logic [7:0] c, input logic first,
                                    output result_t num);
    int d;
    num = '0;
    if (first) begin
      ps_acc  = '0;
      ps_neg  = 1'b0;
      ps_pos  = '0;
      ps_base = cfg_radix;
      if ((ps_base == RADIX_ONE) || (ps_base > RADIX_MAX)) begin
        ps_phase = PH_DONE;
        return 1'b1;
      end
      ps_phase = cfg_signed ? PH_WS1 : PH_WS2;
    end
    if (ps_phase == PH_DONE) return 1'b0;
    if (ps_phase == PH_WS1) begin
      if (is_blank(c)) begin
        bump_pos();
        return 1'b0;
      end
      if (c == CH_MINUS) begin
        ps_neg = 1'b1;
        bump_pos();
        ps_phase = PH_WS2;
        return 1'b0;
      end
      ps_phase = PH_WS2;
    end
    if (ps_phase == PH_WS2) begin
      if (is_blank(c)) begin
        bump_pos();
        return 1'b0;
      end
      ps_phase = (ps_base == RADIX_AUTO) ? PH_PREFIX : PH_DIGITS;
    end
    if (ps_phase == PH_PREFIX) begin
      if (c == CH_ZERO) begin
        bump_pos();
        ps_phase = PH_AFTER0;
        return 1'b0;
      end
      ps_base  = RADIX_DEC;
      ps_phase = PH_DIGITS;
    end
    if (ps_phase == PH_AFTER0) begin
      ps_phase = PH_DIGITS;
      if ((c == CH_LOWER_X) || (c == CH_UPPER_X)) begin
        bump_pos();
        ps_base = RADIX_HEX;
        return 1'b0;
      end
      ps_base = RADIX_OCT;
    end
    d = glyph_value(c);
    if (d < int'(ps_base)) begin
      ps_acc = ps_acc * 64'(ps_base) + 64'(d);
      bump_pos();
      return 1'b0;
    end
    num.value      = ps_neg ? (64'd0 - ps_acc) : ps_acc;
    num.end_offset = ps_pos;
    num.end_valid  = 1'b1;
    ps_phase = PH_DONE;
    return 1'b1;
  endfunction

  task automatic report_miss(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    errors++;
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Scoreboard: results are checked before this edge's character is modelled
  always @(posedge clk) begin
    if (rst_n) begin
      quiet++;
      if (out_bus.valid && out_bus.ready) begin
        quiet = 0;
        n_nums++;
        if (!out_bus.end_valid) n_bad++;
        if (pending_nums.size() == 0) begin
          report_miss("result beat with nothing pending", out_bus.value, '0);
        end else begin
          want_num = pending_nums.pop_front();
          if (out_bus.value !== want_num.value)
            report_miss("value", out_bus.value, want_num.value);
          if (out_bus.end_offset !== want_num.end_offset)
            report_miss("end_offset", 64'(out_bus.end_offset), 64'(want_num.end_offset));
          if (out_bus.end_valid !== want_num.end_valid)
            report_miss("end_valid", 64'(out_bus.end_valid), 64'(want_num.end_valid));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        quiet = 0;
        n_chars++;
        pred_hit = parse_char(in_bus.ch, in_bus.start_req, pred_num);
        if (fixed_row) begin
          pending_nums.push_back(fixed_res);
        end else if (pred_hit) begin
          if (pred_num.end_valid && pred_num.value[63]) n_neg++;
          pending_nums.push_back(pred_num);
        end
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    bit hold_done;
    int run_left;
    hold_done = 1'b0;
    run_left  = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long && !hold_done) begin
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (rx_calm || ($urandom_range(0, 2) != 0)) begin
        out_bus.ready <= 1'b1;
        run_left = $urandom_range(0, 15);
      end else begin
        out_bus.ready <= 1'b0;
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      end
    end
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("[%0t] no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
    $display("tb_text_to_integer_parser failed");
    $finish;
  end

  function automatic int tx_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 13) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic first, input logic fixed,
                           input result_t fres);
    in_bus.valid     <= 1'b1;
    in_bus.ch        <= c;
    in_bus.start_req <= first;
    fixed_row        <= fixed;
    fixed_res        <= fres;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic pause_tx();
    int g;
    g = tx_gap();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drain: stop sending, wait until nothing is pending, then wait out characters still in flight
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_nums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    quiet = 0;
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [RADIX_W-1:0] r, input logic s);
    settle();
    // junk in the unused upper bits
    apb_write(ADDR_RADIX, ($urandom & ~32'h3F) | 32'(r));
    apb_write(ADDR_SIGNED, ($urandom & ~32'h1) | 32'(s));
    cfg_radix  = r;
    cfg_signed = s;
    n_cfg += 2;
  endtask

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  function automatic logic [7:0] make_digit(input int d);
    if (d < 10) return 8'(CH_ZERO + d);
    return 8'(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + d - 10);
  endfunction

  // One string: blanks, optional sign, prefix, digits, terminator; some noise
  task automatic send_string(output int counted);
    logic [7:0] q[$];
    logic [7:0] c;
    int eb, nd, d, i;
    bit restart, bad, auto_dec;
    bad = (cfg_radix == RADIX_ONE) || (cfg_radix > RADIX_MAX);
    auto_dec = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      nd = $urandom_range(1, 6);
      for (i = 0; i < nd; i++) begin
        send_beat(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 3) == 0),
                  1'b0, NONE);
        pause_tx();
      end
      counted = nd;
      return;
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q.push_back(pick_blank());
    if (cfg_signed && ($urandom_range(0, 2) == 0)) begin
      q.push_back(CH_MINUS);
      if ($urandom_range(0, 3) == 0) q.push_back(pick_blank());
    end
    eb = bad ? 10 : int'(cfg_radix);
    if (cfg_radix == RADIX_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          q.push_back(CH_ZERO);
          q.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
          eb = 16;
        end
        1: begin
          q.push_back(CH_ZERO);
          eb = 8;
        end
        default: begin
          eb = 10;
          auto_dec = 1'b1;
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: nd = 0;
      1: nd = $urandom_range(14, 40);
      default: nd = $urandom_range(1, 8);
    endcase
    for (i = 0; i < nd; i++) begin
      d = (auto_dec && (i == 0)) ? $urandom_range(1, 9) : $urandom_range(0, eb - 1);
      q.push_back(make_digit(d));
    end
    restart = ($urandom_range(0, 11) == 0);
    if (!restart || (q.size() == 0)) begin
      if ($urandom_range(0, 3) == 0) begin
        c = 8'h00;
      end else begin
        do c = 8'($urandom_range(0, 255)); while (glyph_value(c) < eb);
      end
      q.push_back(c);
    end
    for (i = 0; i < q.size(); i++) begin
      send_beat(q[i], i == 0, 1'b0, NONE);
      pause_tx();
    end
    counted = bad ? 1 : q.size();
    if (!restart && ($urandom_range(0, 15) == 0)) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, NONE);
      pause_tx();
    end
  endtask

  initial begin : stimulus
    int budget, done_items, got, p;
    logic [RADIX_W-1:0] r;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_bus.valid     = 1'b0;
    in_bus.ch        = '0;
    in_bus.start_req = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, starting from reset settings
    for (int k = 0; k < N_ROWS; k++) begin
      if (DIR_ROWS[k].kind == ROW_CFG) begin
        write_cfg(DIR_ROWS[k].radix, DIR_ROWS[k].sgn);
      end else begin
        send_beat(DIR_ROWS[k].ch, DIR_ROWS[k].start, DIR_ROWS[k].fixed, DIR_ROWS[k].res);
        pause_tx();
      end
    end

    // random strings over a radix / sign sweep
    for (p = 0; p < N_SWEEP; p++) begin
      r = (p == N_SWEEP - 1) ? RADIX_W'($urandom_range(0, 63)) : SWEEP[p];
      write_cfg(r, (p == 1) ? 1'b1 : 1'(($urandom_range(0, 2) != 0) ^ (p % 2)));
      tx_calm = (p == 3) || (p == 5);
      rx_calm <= (p == 4);
      if (p == 3) hold_long <= 1'b1;
      budget = ((r == RADIX_ONE) || (r > RADIX_MAX)) ? 25 : 120;
      done_items = 0;
      while (done_items < budget) begin
        send_string(got);
        done_items += got;
      end
    end
    tx_calm = 1'b0;
    rx_calm <= 1'b0;
    settle();

    $display("%0d character beats in, %0d number beats out (%0d bad base, %0d negative)",
             n_chars, n_nums, n_bad, n_neg);
    $display("%0d register writes: radix sweep incl. 0, 1, 2, 36, 37, 63; long stall",
             n_cfg);
    if (errors == 0) begin
      $display("tb_text_to_integer_parser passed");
    end else begin
      $display("tb_text_to_integer_parser failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/ttip_pkg.sv
design/ttip_if.sv
design/ttip_cfg_regs.sv
design/ttip_step.sv
design/text_to_integer_parser.sv
design/ttip_checker.sv
sim/tb_text_to_integer_parser.sv
